// ===== hw/rtl/rtb_pkg.sv =====
// ----------------------------------------------------------------------------
// rtb_pkg: shared types and constants for the rectangle tile binner
// Field widths, register indexes and the tile span handed to the scanner.
// ----------------------------------------------------------------------------
package rtb_pkg;

  localparam int TILES_PER_SIDE_DEF = 4;
  localparam int COORD_W            = 32;
  localparam int TILE_W             = 3;
  localparam int CFG_IDX_W          = 2;
  localparam int IN_DATA_W          = 4 * COORD_W;
  localparam int OUT_DATA_W         = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LEFT   = 2'd0,
    REG_WINDOW_TOP    = 2'd1,
    REG_WINDOW_RIGHT  = 2'd2,
    REG_WINDOW_BOTTOM = 2'd3
  } reg_idx_t;

  // Covered tile range of one rectangle; covered clear means a single
  // "no overlap" item.
  typedef struct packed {
    logic              covered;
    logic [TILE_W-1:0] row_first;
    logic [TILE_W-1:0] row_last;
    logic [TILE_W-1:0] col_first;
    logic [TILE_W-1:0] col_last;
  } span_t;

endpackage

// ===== hw/rtl/rectangle_tile_binner.sv =====
// ----------------------------------------------------------------------------
// rectangle_tile_binner: axis-aligned rectangle to tile grid binning
// Splits a configured window into an N by N grid and lists the tiles that
// each input rectangle covers, row by row from the window top.
// ----------------------------------------------------------------------------
// Usage:
//   Write the window edges through cfg_we / cfg_index / cfg_data while idle
//   (0 left, 1 top, 2 right, 3 bottom). Each s_axis item is one rectangle.
//   For a rectangle outside the window, an inverted rectangle or a window
//   with no area, one m_axis item with tuser clear and tlast set is given.
//   Otherwise one item per covered tile, tuser set, tlast on the final tile.
// Timing:
//   Four tile indices go one after another through a single restoring
//   divider with QW = clog2(N+1) quotient bits. The first tile item shows
//   once the last index is found, then one item per cycle while the
//   receiver takes them; the no-overlap item shows once the setup step
//   finds no overlap. s_axis_tready rises the cycle after the last item
//   of the previous rectangle is taken, so one rectangle is in flight.
// Reset (rst, synchronous) clears the window to zero and drops any item.
// A stalled receiver holds the current item in the output register and
// the tile walk simply waits.
// ----------------------------------------------------------------------------
module rectangle_tile_binner #(
  parameter int TILES_PER_SIDE = rtb_pkg::TILES_PER_SIDE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [rtb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtb_pkg::COORD_W-1:0]       cfg_data,
  // rectangle items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // fields from bit 0: rect_left, rect_top, rect_right, rect_bottom
  input  logic [rtb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tile items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // fields from bit 0: tile_row, tile_col, zero fill
  output logic [rtb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // fields from bit 0: inside_res
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast
);

  localparam int CW = rtb_pkg::COORD_W;
  localparam int TW = rtb_pkg::TILE_W;

  typedef enum logic [2:0] {S_IDLE, S_SETUP, S_DIV_START, S_DIV_WAIT, S_EMIT} state_t;
  typedef enum logic [1:0] {
    SEL_COL_FIRST, SEL_COL_LAST, SEL_ROW_FIRST, SEL_ROW_LAST
  } idx_sel_t;

  function automatic logic signed [CW:0] sub_wide(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
    logic signed [CW:0] r;
    r = {a[CW-1], a} - {b[CW-1], b};
    return r;
  endfunction

  // window registers
  logic signed [CW-1:0] win_left, win_top, win_right, win_bottom;

  // captured rectangle
  logic signed [CW-1:0] rl, rt, rr, rb;

  state_t               state;
  idx_sel_t             sel;
  logic [CW-1:0]        ext_x, ext_y;
  logic signed [CW:0]   off_cf, off_cl, off_rf, off_rl;
  logic [TW-1:0]        col_first, col_last, row_first;
  logic                 span_load;
  rtb_pkg::span_t       span;

  logic                 degenerate, outside;
  logic signed [CW:0]   ext_x_w, ext_y_w;
  logic                 div_start, div_done;
  logic signed [CW:0]   div_off;
  logic [CW-1:0]        div_ext;
  logic [TW-1:0]        div_index;

  logic                 item_valid, item_inside, item_last;
  logic [TW-1:0]        item_row, item_col;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= '0;
      win_top    <= '0;
      win_right  <= '0;
      win_bottom <= '0;
    end else if (cfg_we) begin
      unique case (rtb_pkg::reg_idx_t'(cfg_index))
        rtb_pkg::REG_WINDOW_LEFT:   win_left   <= cfg_data;
        rtb_pkg::REG_WINDOW_TOP:    win_top    <= cfg_data;
        rtb_pkg::REG_WINDOW_RIGHT:  win_right  <= cfg_data;
        rtb_pkg::REG_WINDOW_BOTTOM: win_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  // overlap tests and extents, all side by side
  assign degenerate = (win_right <= win_left) || (win_top <= win_bottom);
  assign outside    = (rt < win_bottom) || (rb > win_top) || (rl > win_right) ||
                      (rr < win_left) || (rl > rr) || (rb > rt);
  assign ext_x_w    = sub_wide(win_right, win_left);
  assign ext_y_w    = sub_wide(win_top, win_bottom);

  // feed the shared divider with the offset for the current index
  always_comb begin
    case (sel)
      SEL_COL_FIRST: div_off = off_cf;
      SEL_COL_LAST:  div_off = off_cl;
      SEL_ROW_FIRST: div_off = off_rf;
      default:       div_off = off_rl;
    endcase
  end
  assign div_ext   = ((sel == SEL_COL_FIRST) || (sel == SEL_COL_LAST)) ? ext_x : ext_y;
  assign div_start = (state == S_DIV_START);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      span_load <= 1'b0;
    end else begin
      span_load <= 1'b0;
      unique case (state)
        S_IDLE: begin
          // capture the rectangle
          if (s_axis_tvalid) begin
            rl    <= s_axis_tdata[CW-1:0];
            rt    <= s_axis_tdata[2*CW-1:CW];
            rr    <= s_axis_tdata[3*CW-1:2*CW];
            rb    <= s_axis_tdata[4*CW-1:3*CW];
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (degenerate || outside) begin
            span      <= '0;
            span_load <= 1'b1;
            state     <= S_EMIT;
          end else begin
            ext_x  <= ext_x_w[CW-1:0];
            ext_y  <= ext_y_w[CW-1:0];
            off_cf <= sub_wide(rl, win_left);
            off_cl <= sub_wide(rr, win_left);
            off_rf <= sub_wide(win_top, rt);
            off_rl <= sub_wide(win_top, rb);
            sel    <= SEL_COL_FIRST;
            state  <= S_DIV_START;
          end
        end
        S_DIV_START: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            case (sel)
              SEL_COL_FIRST: col_first <= div_index;
              SEL_COL_LAST:  col_last  <= div_index;
              SEL_ROW_FIRST: row_first <= div_index;
              default: ;
            endcase
            if (sel == SEL_ROW_LAST) begin
              // last index arrives now: hand the span over directly
              span.covered   <= 1'b1;
              span.row_first <= row_first;
              span.row_last  <= div_index;
              span.col_first <= col_first;
              span.col_last  <= col_last;
              span_load      <= 1'b1;
              state          <= S_EMIT;
            end else begin
              sel   <= idx_sel_t'(sel + 2'd1);
              state <= S_DIV_START;
            end
          end
        end
        S_EMIT: begin
          if (item_valid && m_axis_tready && item_last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);

  rtb_div_unit #(
    .TILES_PER_SIDE (TILES_PER_SIDE)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .off   (div_off),
    .ext   (div_ext),
    .done  (div_done),
    .index (div_index)
  );

  rtb_tile_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .load        (span_load),
    .span        (span),
    .item_valid  (item_valid),
    .item_ready  (m_axis_tready),
    .item_inside (item_inside),
    .item_row    (item_row),
    .item_col    (item_col),
    .item_last   (item_last)
  );

  assign m_axis_tvalid = item_valid;
  assign m_axis_tdata  = {{(rtb_pkg::OUT_DATA_W - 2 * TW){1'b0}}, item_col, item_row};
  assign m_axis_tuser  = item_inside;
  assign m_axis_tlast  = item_last;

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input taken while tile items still pending");

  a_span_ordered: assert property (@(posedge clk) disable iff (rst)
    (span_load && span.covered) |->
      ((span.col_first <= span.col_last) && (span.row_first <= span.row_last)))
    else $error("tile span out of order");

endmodule

// ===== hw/rtl/rtb_div_unit.sv =====
// ----------------------------------------------------------------------------
// rtb_div_unit: iterative tile index unit
// Clamps an offset to [0, extent], then finds floor(offset * N / extent)
// with a restoring divider, one quotient bit per cycle, clamped to N-1.
// ----------------------------------------------------------------------------
module rtb_div_unit #(
  parameter int TILES_PER_SIDE = rtb_pkg::TILES_PER_SIDE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [rtb_pkg::COORD_W:0] off,
  input  logic [rtb_pkg::COORD_W-1:0]     ext,
  output logic                            done,
  output logic [rtb_pkg::TILE_W-1:0]      index
);

  localparam int QW = $clog2(TILES_PER_SIDE + 1);
  localparam int MW = rtb_pkg::COORD_W + QW;
  localparam int CW = $clog2(QW + 1);

  typedef enum logic [1:0] {D_IDLE, D_MUL, D_STEP} div_state_t;

  div_state_t                  state;
  logic [rtb_pkg::COORD_W-1:0] off_c;
  logic [rtb_pkg::COORD_W-1:0] ext_r;
  logic [MW-1:0]               rem;
  logic [MW-1:0]               dvs;
  logic [QW-1:0]               quo;
  logic [CW-1:0]               cnt;

  logic          ge;
  logic [MW-1:0] diff;
  logic [QW-1:0] quo_next;

  assign ge       = (rem >= dvs);
  assign diff     = rem - dvs;
  assign quo_next = QW'({quo, ge});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            // negative or zero offset lands in tile 0; beyond the extent is the far edge
            if (off[rtb_pkg::COORD_W] || (off == '0)) begin
              off_c <= '0;
            end else if (off[rtb_pkg::COORD_W-1:0] >= ext) begin
              off_c <= ext;
            end else begin
              off_c <= off[rtb_pkg::COORD_W-1:0];
            end
            ext_r <= ext;
            state <= D_MUL;
          end
        end
        D_MUL: begin
          rem   <= MW'(off_c) * MW'(TILES_PER_SIDE);
          dvs   <= MW'(ext_r) << (QW - 1);
          quo   <= '0;
          cnt   <= CW'(QW);
          state <= D_STEP;
        end
        D_STEP: begin
          if (ge) begin
            rem <= diff;
          end
          dvs <= dvs >> 1;
          quo <= quo_next;
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            done <= 1'b1;
            if (quo_next > QW'(TILES_PER_SIDE - 1)) begin
              index <= rtb_pkg::TILE_W'(TILES_PER_SIDE - 1);
            end else begin
              index <= rtb_pkg::TILE_W'(quo_next);
            end
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  a_index_in_grid: assert property (@(posedge clk) disable iff (rst)
    done |-> (index <= rtb_pkg::TILE_W'(TILES_PER_SIDE - 1)))
    else $error("tile index beyond grid");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && state == D_IDLE))
    else $error("done held for more than one cycle");

endmodule

// ===== hw/rtl/rtb_tile_scan.sv =====
// ----------------------------------------------------------------------------
// rtb_tile_scan: covered tile walker and output register
// Walks the tile span row by row, one item per accepted handshake.
// ----------------------------------------------------------------------------
module rtb_tile_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  rtb_pkg::span_t             span,
  output logic                       item_valid,
  input  logic                       item_ready,
  output logic                       item_inside,
  output logic [rtb_pkg::TILE_W-1:0] item_row,
  output logic [rtb_pkg::TILE_W-1:0] item_col,
  output logic                       item_last
);

  rtb_pkg::span_t             sp;
  logic [rtb_pkg::TILE_W-1:0] row;
  logic [rtb_pkg::TILE_W-1:0] col;
  logic                       valid;

  logic at_end;
  assign at_end = !sp.covered || ((row == sp.row_last) && (col == sp.col_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
      sp    <= span;
      row   <= span.row_first;
      col   <= span.col_first;
    end else if (valid && item_ready) begin
      if (at_end) begin
        valid <= 1'b0;
      end else if (col == sp.col_last) begin
        col <= sp.col_first;
        row <= row + rtb_pkg::TILE_W'(1);
      end else begin
        col <= col + rtb_pkg::TILE_W'(1);
      end
    end
  end

  assign item_valid  = valid;
  assign item_inside = sp.covered;
  assign item_row    = row;
  assign item_col    = col;
  assign item_last   = at_end;

  a_within_span: assert property (@(posedge clk) disable iff (rst)
    (valid && sp.covered) |-> ((row <= sp.row_last) && (col <= sp.col_last)))
    else $error("scan left the tile span");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    load |-> !valid)
    else $error("span loaded over a pending item");

endmodule
